// File: src/urc_pkg.sv
// Package for the ultrasonic range controller.
// Holds the phase and status codes, timing constants and the result struct.
// No dependencies.
package urc_pkg;

  localparam int unsigned CpuW  = 8;
  localparam int unsigned ToW   = 16;
  localparam int unsigned McW   = 17;
  localparam int unsigned ResW  = 6;
  localparam int unsigned CmW   = 11;
  localparam int unsigned CfgDW = 16;

  localparam logic [McW-1:0]  US_TRIG_LOW  = McW'(2);
  localparam logic [McW-1:0]  US_TRIG_HIGH = McW'(10);
  localparam logic [ResW-1:0] US_PER_CM    = ResW'(58);
  localparam logic [McW-1:0]  MICRO_MAX    = {McW{1'b1}};
  localparam logic [CmW-1:0]  CM_MAX       = {CmW{1'b1}};

  localparam logic [CpuW-1:0] CPU_RESET = CpuW'(16);
  localparam logic [ToW-1:0]  TO_RESET  = ToW'(30000);

  typedef enum logic {
    REG_CYCLES_PER_US = 1'b0,
    REG_TIMEOUT_US    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_WAIT_FALL = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    STAT_OK            = 2'd0,
    STAT_ECHO_AT_START = 2'd1,
    STAT_NO_RISE       = 2'd2,
    STAT_TOO_LONG      = 2'd3
  } status_t;

  typedef struct packed {
    logic           trig;
    logic           busy_res;
    logic           done_res;
    logic [CmW-1:0] distance_cm;
    status_t        status;
  } result_t;

endpackage

// File: src/urc_if.sv
// Channel interfaces for the ultrasonic range controller.
// Depends on urc_pkg for field widths.
interface urc_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink (input valid, input start_req, input echo, output ready);
endinterface

interface urc_out_if;
  logic                    valid;
  logic                    ready;
  logic                    trig;
  logic                    busy_res;
  logic                    done_res;
  logic [urc_pkg::CmW-1:0] distance_cm;
  logic [1:0]              status;

  modport source (output valid, output trig, output busy_res, output done_res,
                  output distance_cm, output status, input ready);
  modport sink (input valid, input trig, input busy_res, input done_res,
                input distance_cm, input status, output ready);
endinterface

// File: src/urc_core.sv
// Ranging sequencer: phase machine and the cycle/us/cm counter cascade.
// Steps once per transferred tick. Depends on urc_pkg.
module urc_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic                     start_req,
  input  logic                     echo,
  input  logic [urc_pkg::CpuW-1:0] cycles_per_us,
  input  logic [urc_pkg::ToW-1:0]  timeout_us,
  output urc_pkg::result_t         result
);
  import urc_pkg::*;

  phase_t          phase, phase_next;
  logic [CpuW-1:0] cycle_prescale, cycle_prescale_next;
  logic [McW-1:0]  micro_count, micro_count_next;
  logic [ResW-1:0] cm_residue, cm_residue_next;
  logic [CmW-1:0]  cm_count, cm_count_next;
  logic [CmW-1:0]  last_distance, last_distance_next;
  logic            done;
  status_t         status;

  // advance of the cascade for this tick
  logic [CpuW:0]   cpu_eff;
  logic [CpuW:0]   ps_inc;
  logic            us_tick;
  logic [ResW-1:0] res_inc;
  logic            cm_wrap;
  logic [CpuW-1:0] adv_ps;
  logic [McW-1:0]  adv_mc;
  logic [ResW-1:0] adv_res;
  logic [CmW-1:0]  adv_cm;
  logic            adv_timeout;

  always_comb begin
    cpu_eff = (cycles_per_us == '0) ? (CpuW+1)'(1) : {1'b0, cycles_per_us};
    ps_inc  = {1'b0, cycle_prescale} + (CpuW+1)'(1);
    us_tick = (ps_inc >= cpu_eff);
    res_inc = cm_residue + ResW'(1);
    cm_wrap = us_tick && (res_inc >= US_PER_CM);
    adv_ps  = us_tick ? '0 : ps_inc[CpuW-1:0];
    adv_mc  = (us_tick && micro_count != MICRO_MAX) ? micro_count + McW'(1) : micro_count;
    adv_res = us_tick ? (cm_wrap ? '0 : res_inc) : cm_residue;
    adv_cm  = (cm_wrap && cm_count != CM_MAX) ? cm_count + CmW'(1) : cm_count;
    adv_timeout = (adv_mc > {1'b0, timeout_us}) ||
                  ((adv_mc == {1'b0, timeout_us}) && (adv_ps != '0));
  end

  // next state
  always_comb begin
    phase_next          = phase;
    cycle_prescale_next = cycle_prescale;
    micro_count_next    = micro_count;
    cm_residue_next     = cm_residue;
    cm_count_next       = cm_count;
    last_distance_next  = last_distance;
    done                = 1'b0;
    status              = STAT_OK;
    unique case (phase)
      PH_TRIG_LOW: begin
        if (adv_mc >= US_TRIG_LOW) begin
          phase_next          = PH_TRIG_HIGH;
          cycle_prescale_next = '0;
          micro_count_next    = '0;
          cm_residue_next     = '0;
          cm_count_next       = '0;
        end else begin
          cycle_prescale_next = adv_ps;
          micro_count_next    = adv_mc;
          cm_residue_next     = adv_res;
          cm_count_next       = adv_cm;
        end
      end
      PH_TRIG_HIGH: begin
        if (adv_mc >= US_TRIG_HIGH) begin
          phase_next          = PH_WAIT_RISE;
          cycle_prescale_next = '0;
          micro_count_next    = '0;
          cm_residue_next     = '0;
          cm_count_next       = '0;
        end else begin
          cycle_prescale_next = adv_ps;
          micro_count_next    = adv_mc;
          cm_residue_next     = adv_res;
          cm_count_next       = adv_cm;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          phase_next          = PH_WAIT_FALL;
          cycle_prescale_next = '0;
          micro_count_next    = '0;
          cm_residue_next     = '0;
          cm_count_next       = '0;
        end else begin
          cycle_prescale_next = adv_ps;
          micro_count_next    = adv_mc;
          cm_residue_next     = adv_res;
          cm_count_next       = adv_cm;
          if (adv_timeout) begin
            done               = 1'b1;
            status             = STAT_NO_RISE;
            last_distance_next = '0;
            phase_next         = PH_IDLE;
          end
        end
      end
      PH_WAIT_FALL: begin
        cycle_prescale_next = adv_ps;
        micro_count_next    = adv_mc;
        cm_residue_next     = adv_res;
        cm_count_next       = adv_cm;
        if (!echo) begin
          done               = 1'b1;
          status             = STAT_OK;
          last_distance_next = adv_cm;
          phase_next         = PH_IDLE;
        end else if (adv_timeout) begin
          done               = 1'b1;
          status             = STAT_TOO_LONG;
          last_distance_next = '0;
          phase_next         = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (start_req) begin
          if (echo) begin
            done               = 1'b1;
            status             = STAT_ECHO_AT_START;
            last_distance_next = '0;
          end else begin
            phase_next          = PH_TRIG_LOW;
            cycle_prescale_next = '0;
            micro_count_next    = '0;
            cm_residue_next     = '0;
            cm_count_next       = '0;
          end
        end
      end
    endcase
  end

  // result of this tick
  always_comb begin
    result.trig        = (phase_next == PH_TRIG_HIGH);
    result.busy_res    = (phase_next != PH_IDLE);
    result.done_res    = done;
    result.distance_cm = last_distance_next;
    result.status      = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      cycle_prescale <= '0;
      micro_count    <= '0;
      cm_residue     <= '0;
      cm_count       <= '0;
      last_distance  <= '0;
    end else if (step) begin
      phase          <= phase_next;
      cycle_prescale <= cycle_prescale_next;
      micro_count    <= micro_count_next;
      cm_residue     <= cm_residue_next;
      cm_count       <= cm_count_next;
      last_distance  <= last_distance_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_residue_range: assert property (@(posedge clk) disable iff (rst)
    cm_residue < US_PER_CM)
    else $error("cm residue out of range");
  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_IDLE && phase_next == PH_TRIG_LOW |=> micro_count == '0)
    else $error("counters not cleared on start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && done |=> phase == PH_IDLE)
    else $error("finished measurement did not return to idle");
`endif
endmodule

// File: src/ultrasonic_range_controller_top.sv
// Top level of the ultrasonic range controller: config registers, input
// handshake and result register. Depends on urc_pkg, urc_if and urc_core.
//
// Usage: every input transfer is one clock tick of the sensor, carrying a
// start request and the sampled echo level. Every input transfer yields
// exactly one result transfer: trigger level, busy, done, distance in cm
// and status for the state after that tick.
// Result: registered, and valid in the cycle after the input transfer.
// Throughput: one tick per cycle when not stalled; all work for a tick is
// one pass through the phase machine and the cycle/us/cm counter cascade.
// Config: cfg_we writes cfg_data to register cfg_index (0 cycles_per_us, 1
// timeout_us); unenforced: the user writes only with no tick outstanding.
// Reset: synchronous rst returns to idle, clears the counters and the last
// distance, loads cycles_per_us 16 and timeout_us 30000, and empties the
// result register.
// Stall: while a result waits and out_ch.ready is low, in_ch.ready is low;
// input is taken in the same cycle the waiting result is taken.
module ultrasonic_range_controller_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [urc_pkg::CfgDW-1:0] cfg_data,
  urc_in_if.sink                    in_ch,
  urc_out_if.source                 out_ch
);
  import urc_pkg::*;

  logic [CpuW-1:0] cycles_per_us;
  logic [ToW-1:0]  timeout_us;
  logic            step;
  result_t         result;
  result_t         out_res;
  logic            out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_us <= CPU_RESET;
      timeout_us    <= TO_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CYCLES_PER_US: cycles_per_us <= cfg_data[CpuW-1:0];
        REG_TIMEOUT_US:    timeout_us    <= cfg_data[ToW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  urc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .start_req     (in_ch.start_req),
    .echo          (in_ch.echo),
    .cycles_per_us (cycles_per_us),
    .timeout_us    (timeout_us),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= result;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.trig        = out_res.trig;
  assign out_ch.busy_res    = out_res.busy_res;
  assign out_ch.done_res    = out_res.done_res;
  assign out_ch.distance_cm = out_res.distance_cm;
  assign out_ch.status      = out_res.status;

`ifndef NO_ASSERTIONS
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_ch.valid)
    else $error("transfer produced no result");
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done while busy");
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != STAT_OK |-> out_ch.distance_cm == '0)
    else $error("error status with nonzero distance");
  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.trig |-> out_ch.busy_res && !out_ch.done_res)
    else $error("trigger outside a measurement");
`endif
endmodule

// File: bench/tb_ultrasonic_range_controller_top.sv
// Testbench for ultrasonic_range_controller_top: drives sensor ticks, tracks trigger/echo
// timing and distance with a tick-accurate ranging model, checks every result transfer.
// Depends on urc_pkg, urc_if and the RTL under src.
module tb_ultrasonic_range_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import urc_pkg::*;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CfgDW-1:0] cfg_data;

  urc_in_if  in_ch ();
  urc_out_if out_ch ();

  ultrasonic_range_controller_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;

  // ranging model state
  logic [CpuW-1:0] cfg_cpu;
  logic [ToW-1:0]  cfg_to;
  phase_t          rg_phase;
  logic [CpuW-1:0] rg_pre;
  logic [McW-1:0]  rg_us;
  logic [ResW-1:0] rg_res;
  logic [CmW-1:0]  rg_cm;
  logic [CmW-1:0]  rg_last;

  result_t pending_readings[$];
  int      ticks_sent;
  int      fail_count;
  int      src_idle_pct;
  int      sink_stall_pct;
  bit      stall_burst;
  int      hold_left;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_counts();
    rg_pre = '0;
    rg_us  = '0;
    rg_res = '0;
    rg_cm  = '0;
  endfunction

  function automatic void count_cycle();
    if ({1'b0, rg_pre} + 9'd1 >= {1'b0, cfg_cpu}) begin
      rg_pre = '0;
      if (rg_us != MICRO_MAX) rg_us = rg_us + 1'b1;
      rg_res = rg_res + 1'b1;
      if (rg_res >= US_PER_CM) begin
        rg_res = '0;
        if (rg_cm != CM_MAX) rg_cm = rg_cm + 1'b1;
      end
    end else begin
      rg_pre = rg_pre + 1'b1;
    end
  endfunction

  function automatic bit wait_expired();
    return (rg_us > {1'b0, cfg_to}) || (rg_us == {1'b0, cfg_to} && rg_pre != '0);
  endfunction

  function automatic result_t step_ranger(input logic s, input logic e);
    result_t r;
    logic    fin;
    status_t st;
    fin = 1'b0;
    st  = STAT_OK;
    case (rg_phase)
      PH_TRIG_LOW: begin
        count_cycle();
        if (rg_us >= US_TRIG_LOW) begin
          rg_phase = PH_TRIG_HIGH;
          clear_counts();
        end
      end
      PH_TRIG_HIGH: begin
        count_cycle();
        if (rg_us >= US_TRIG_HIGH) begin
          rg_phase = PH_WAIT_RISE;
          clear_counts();
        end
      end
      PH_WAIT_RISE: begin
        if (e) begin
          rg_phase = PH_WAIT_FALL;
          clear_counts();
        end else begin
          count_cycle();
          if (wait_expired()) begin
            fin      = 1'b1;
            st       = STAT_NO_RISE;
            rg_last  = '0;
            rg_phase = PH_IDLE;
          end
        end
      end
      PH_WAIT_FALL: begin
        count_cycle();
        if (!e) begin
          fin      = 1'b1;
          st       = STAT_OK;
          rg_last  = rg_cm;
          rg_phase = PH_IDLE;
        end else if (wait_expired()) begin
          fin      = 1'b1;
          st       = STAT_TOO_LONG;
          rg_last  = '0;
          rg_phase = PH_IDLE;
        end
      end
      default: begin
        rg_phase = PH_IDLE;
        if (s) begin
          if (e) begin
            fin     = 1'b1;
            st      = STAT_ECHO_AT_START;
            rg_last = '0;
          end else begin
            rg_phase = PH_TRIG_LOW;
            clear_counts();
          end
        end
      end
    endcase
    r.trig        = (rg_phase == PH_TRIG_HIGH);
    r.busy_res    = (rg_phase != PH_IDLE);
    r.done_res    = fin;
    r.distance_cm = rg_last;
    r.status      = st;
    return r;
  endfunction

  task automatic send_tick(input logic s, input logic e);
    result_t r;
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.start_req <= s;
    in_ch.echo      <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = step_ranger(s, e);
    pending_readings.push_back(r);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CfgDW-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CYCLES_PER_US) cfg_cpu = val[CpuW-1:0];
    else cfg_to = val;
  endtask

  task automatic set_idle(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // one start plus the echo pulse; start_req toggles at random while running
  task automatic run_measurement(input bit echo_at_start, input int rise_wait,
                                 input int high_len);
    send_tick(1'b1, echo_at_start);
    while (rg_phase == PH_TRIG_LOW || rg_phase == PH_TRIG_HIGH)
      send_tick(1'($urandom_range(0, 1)), 1'b0);
    for (int i = 0; i < rise_wait && rg_phase == PH_WAIT_RISE; i++)
      send_tick(1'($urandom_range(0, 1)), 1'b0);
    if (rg_phase == PH_WAIT_RISE) send_tick(1'($urandom_range(0, 1)), 1'b1);
    for (int i = 0; i < high_len && rg_phase == PH_WAIT_FALL; i++)
      send_tick(1'($urandom_range(0, 1)), 1'b1);
    if (rg_phase == PH_WAIT_FALL) send_tick(1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++)
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_config();
    set_idle(0, 0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    run_measurement(1'b1, 0, 0);
    run_measurement(1'b0, 3, 20);
  endtask

  task automatic test_status_cases();
    write_reg(REG_CYCLES_PER_US, 16'h0001);
    write_reg(REG_TIMEOUT_US, 16'h0004);
    run_measurement(1'b1, 0, 0);
    run_measurement(1'b0, 10, 0);
    run_measurement(1'b0, 1, 10);
    run_measurement(1'b0, 0, 0);
    run_measurement(1'b0, 2, 3);
    // zero prescale acts as a cycles_per_us of one, zero timeout gives up at once
    write_reg(REG_CYCLES_PER_US, 16'hA500);
    write_reg(REG_TIMEOUT_US, 16'h0000);
    run_measurement(1'b0, 5, 0);
    run_measurement(1'b0, 0, 5);
    write_reg(REG_CYCLES_PER_US, 16'h0003);
    run_measurement(1'b0, 4, 0);
    run_measurement(1'b0, 0, 4);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_CYCLES_PER_US, 16'h0001);
    write_reg(REG_TIMEOUT_US, 16'hFFFF);
    run_measurement(1'b0, 2, 130);
    write_reg(REG_CYCLES_PER_US, 16'h5AFF);
    write_reg(REG_TIMEOUT_US, 16'h0001);
    // prescaler runs deep at the top rate, then the rate drops mid-trigger
    send_tick(1'b1, 1'b0);
    repeat (40) send_tick(1'b0, 1'b0);
    write_reg(REG_CYCLES_PER_US, 16'h0001);
    run_measurement(1'b0, 600, 0);
    run_measurement(1'b0, 0, 600);
  endtask

  task automatic test_backpressure();
    write_reg(REG_CYCLES_PER_US, 16'h0002);
    write_reg(REG_TIMEOUT_US, 16'd20);
    set_idle(0, 0);
    stall_burst = 1'b1;
    run_measurement(1'b0, 5, 30);
    wait_drained();
    run_measurement(1'b0, 1, 60);
  endtask

  task automatic test_random_ranging();
    int goal;
    int n;
    int c;
    int roll;
    logic [CfgDW-1:0] cpu_val;
    logic [CfgDW-1:0] to_val;
    goal = ticks_sent + 650;
    n    = 0;
    while (ticks_sent < goal) begin
      case ((n / 2) % 4)
        0: set_idle(0, 0);
        1: set_idle(64, 0);
        2: set_idle(0, 64);
        default: set_idle(21, 21);
      endcase
      if (n % 4 == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) cpu_val = CfgDW'($urandom_range(1, 2));
        else if (roll < 85) cpu_val = CfgDW'($urandom_range(3, 6));
        else cpu_val = {8'($urandom_range(0, 255)), 8'h00};
        if ($urandom_range(0, 3) == 0 && cpu_val[CpuW-1:0] <= 2)
          to_val = CfgDW'($urandom_range(60, 150));
        else
          to_val = CfgDW'($urandom_range(0, 20));
        if ($urandom_range(0, 1)) begin
          write_reg(REG_CYCLES_PER_US, cpu_val);
          write_reg(REG_TIMEOUT_US, to_val);
        end else begin
          write_reg(REG_TIMEOUT_US, to_val);
          write_reg(REG_CYCLES_PER_US, cpu_val);
        end
      end
      if (n == 5) stall_burst = 1'b1;
      c = (cfg_cpu == '0) ? 1 : int'(cfg_cpu);
      if ($urandom_range(0, 99) < 12) begin
        send_noise($urandom_range(1, 12));
      end else begin
        run_measurement($urandom_range(0, 9) == 0,
                        $urandom_range(0, int'(cfg_to) * c + c + 2),
                        $urandom_range(0, int'(cfg_to) * c + c + 2));
      end
      n++;
    end
  endtask

  // result sink: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (stall_burst) begin
      hold_left   = HoldCycles;
      stall_burst = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $error("result transfer with no tick outstanding");
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (out_ch.trig !== want.trig) begin
          $error("trig: expected %0d, got %0d", want.trig, out_ch.trig);
          fail_count++;
        end
        if (out_ch.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_ch.busy_res);
          fail_count++;
        end
        if (out_ch.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_ch.done_res);
          fail_count++;
        end
        if (out_ch.distance_cm !== want.distance_cm) begin
          $error("distance_cm: expected %0d, got %0d", want.distance_cm,
                 out_ch.distance_cm);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_ultrasonic_range_controller_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_CYCLES_PER_US;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.start_req <= 1'b0;
    in_ch.echo      <= 1'b0;
    stall_burst     = 1'b0;
    ticks_sent      = 0;
    fail_count      = 0;
    set_idle(0, 0);
    cfg_cpu  = CPU_RESET;
    cfg_to   = TO_RESET;
    rg_phase = PH_IDLE;
    rg_last  = '0;
    clear_counts();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_status_cases();
    test_register_extremes();
    test_backpressure();
    test_random_ranging();

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_ultrasonic_range_controller_top passed");
    end else begin
      $display("tb_ultrasonic_range_controller_top failed");
    end
    $finish;
  end

endmodule
